### src/stc_pkg.sv
// shared types, constants and register codes of the scope trigger capture block
package stc_pkg;

  localparam int FRAME_DEPTH_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int POS_W = 6;
  localparam int COUNT_W = 16;
  localparam int LEVEL_W = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 2'd3;

  localparam logic               MODE_ROLL      = 1'b0;
  localparam logic               MODE_RESET     = 1'b1;
  localparam logic [COUNT_W-1:0] PERIOD_RESET   = 16'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET    = 12'd2048;
  localparam logic [COUNT_W-1:0] TIMEOUT_RESET  = 16'd20000;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_WAIT_LOW  = 3'b001,
    PH_WAIT_HIGH = 3'b010,
    PH_CAPTURE   = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    S_RUN     = 2'b01,
    S_PUBLISH = 2'b10
  } seq_t;

  typedef struct packed {
    logic               mode;
    logic [COUNT_W-1:0] period;
    logic [LEVEL_W-1:0] level;
    logic [COUNT_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic roll_insert;
    logic cap_write;
    logic publish;
    logic tflag;
  } cmd_t;

endpackage

### src/stc_if.sv
// valid/ready channel interfaces for converter ticks and frame samples
interface stc_tick_if import stc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink (input valid, input adc_code, output ready);
endinterface

interface stc_frame_if import stc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] frame_sample;
  logic [POS_W-1:0]       sample_position;
  logic                   frame_last;
  logic                   timed_out;

  modport source (output valid, output frame_sample, output sample_position,
                  output frame_last, output timed_out, input ready);
  modport sink (input valid, input frame_sample, input sample_position,
                input frame_last, input timed_out, output ready);
endinterface

### src/scope_trigger_capture.sv
// top level: config registers, sample cell chain and frame readout sequencer
// a tick that completes a frame shows its first sample on the next cycle
// a frame is read out one sample per cycle while the output is not stalled, as the chain
//   rotates toward the output; no new tick is taken until the last sample is out
// a mode switch realigns the chain before the next tick is taken
// reset (synchronous): store cleared, registers at defaults, triggered mode armed
module scope_trigger_capture import stc_pkg::*; #(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  stc_tick_if.sink               tick,
  stc_frame_if.source            frame
);

  localparam int IDX_W = $clog2(FRAME_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_DEPTH - 1);

  cfg_t             cfg;
  logic             rearm;
  cmd_t             cmd;
  logic [IDX_W-1:0] cap_index;
  seq_t             state;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] win_head;
  logic [IDX_W-1:0] align_head;
  logic [IDX_W-1:0] pub_count;
  logic             pub_tflag;
  logic             tick_fire;
  logic             frame_fire;
  logic             align;
  logic             shift;

  logic [SAMPLE_BITS-1:0] store_q [FRAME_DEPTH];

  assign rearm = cfg_we && (cfg_index == REG_MODE) && (cfg_data[0] != cfg.mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_RESET;
      cfg.period <= PERIOD_RESET;
      cfg.level <= LEVEL_RESET;
      cfg.timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:    cfg.mode <= cfg_data[0];
        REG_PERIOD:  cfg.period <= cfg_data;
        REG_LEVEL:   cfg.level <= cfg_data[LEVEL_W-1:0];
        REG_TIMEOUT: cfg.timeout <= cfg_data;
        default:     cfg.mode <= cfg.mode;
      endcase
    end
  end

  // roll mode needs the window head in cell 0, capture writes by absolute index from zero
  assign align_head = (cfg.mode == MODE_ROLL) ? win_head : '0;
  assign align = (state == S_RUN) && (head != align_head);
  assign tick.ready = (state == S_RUN) && (head == align_head);
  assign tick_fire = tick.valid && tick.ready;
  assign frame_fire = frame.valid && frame.ready;
  assign shift = cmd.roll_insert || align || frame_fire;

  stc_ctrl #(
    .FRAME_DEPTH(FRAME_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .rearm(rearm),
    .accept(tick_fire),
    .code(tick.adc_code),
    .cmd(cmd),
    .cap_index(cap_index)
  );

  // cell 0 holds the oldest sample; cell 0 wraps into the last cell on rotation
  for (genvar j = 0; j < FRAME_DEPTH; j++) begin : g_cell
    logic [SAMPLE_BITS-1:0] neighbor;
    logic                   load;
    if (j == FRAME_DEPTH - 1) begin : g_end
      assign neighbor = store_q[0];
      assign load = cmd.roll_insert || (cmd.cap_write && cap_index == IDX_W'(j));
    end else begin : g_mid
      assign neighbor = store_q[j+1];
      assign load = cmd.cap_write && cap_index == IDX_W'(j);
    end
    stc_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .shift(shift),
      .load(load),
      .neighbor(neighbor),
      .code(tick.adc_code),
      .q(store_q[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      head <= '0;
      win_head <= '0;
      pub_count <= '0;
      pub_tflag <= 1'b0;
    end else begin
      case (state)
        S_PUBLISH: begin
          if (frame_fire) begin
            pub_count <= (pub_count == LAST_IDX) ? '0 : pub_count + 1'b1;
            if (pub_count == LAST_IDX) begin
              state <= S_RUN;
            end
          end
        end
        default: begin
          if (cmd.roll_insert || align) begin
            head <= (head == LAST_IDX) ? '0 : head + 1'b1;
          end
          if (cmd.roll_insert) begin
            win_head <= (win_head == LAST_IDX) ? '0 : win_head + 1'b1;
          end else if (cmd.cap_write && cmd.publish) begin
            win_head <= '0;
          end
          if (cmd.publish) begin
            state <= S_PUBLISH;
            pub_count <= '0;
            pub_tflag <= cmd.tflag;
          end
        end
      endcase
    end
  end

  assign frame.valid = (state == S_PUBLISH);
  assign frame.frame_sample = store_q[0];
  assign frame.sample_position = POS_W'(pub_count);
  assign frame.frame_last = (pub_count == LAST_IDX);
  assign frame.timed_out = pub_tflag;

  a_cap_aligned: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_write |-> head == '0)
    else $error("capture write with chain not aligned");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    frame_fire && frame.frame_last |=> state == S_RUN && pub_count == '0)
    else $error("readout did not end after last sample");

  a_pub_start: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_PUBLISH) |-> pub_count == '0)
    else $error("readout started at nonzero position");

  a_no_tick_in_readout: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> !tick.ready)
    else $error("tick accepted during frame readout");

endmodule

### src/stc_cell.sv
// one sample cell of the store chain: load a code, take the neighbor or hold
module stc_cell import stc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic                   load,
  input  logic [SAMPLE_BITS-1:0] neighbor,
  input  logic [SAMPLE_BITS-1:0] code,
  output logic [SAMPLE_BITS-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (load) begin
      q <= code;
    end else if (shift) begin
      q <= neighbor;
    end
  end

endmodule

### src/stc_ctrl.sv
// acquisition control: sample timing, arming, trigger detection and capture count
module stc_ctrl import stc_pkg::*; #(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  logic                           rearm,
  input  logic                           accept,
  input  logic [SAMPLE_BITS-1:0]         code,
  output cmd_t                           cmd,
  output logic [$clog2(FRAME_DEPTH)-1:0] cap_index
);

  localparam int IDX_W = $clog2(FRAME_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_DEPTH - 1);

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] period_count, period_count_next;
  logic [COUNT_W-1:0] arm_count, arm_count_next;
  logic [IDX_W-1:0]   cap_index_next;
  logic               timeout_flag, timeout_flag_next;

  logic [COUNT_W-1:0]     period_bump;
  logic [COUNT_W-1:0]     arm_bump;
  logic [SAMPLE_BITS-1:0] level;

  assign period_bump = (period_count == COUNT_MAX) ? period_count : period_count + 1'b1;
  assign arm_bump = (arm_count == COUNT_MAX) ? arm_count : arm_count + 1'b1;
  assign level = SAMPLE_BITS'(cfg.level);

  always_comb begin
    phase_next = phase;
    period_count_next = period_count;
    arm_count_next = arm_count;
    cap_index_next = cap_index;
    timeout_flag_next = timeout_flag;
    cmd = '0;
    if (rearm) begin
      phase_next = PH_WAIT_LOW;
      period_count_next = '0;
      arm_count_next = '0;
      cap_index_next = '0;
      timeout_flag_next = 1'b0;
    end else if (accept) begin
      if (cfg.mode == MODE_ROLL) begin
        if (period_bump < cfg.period) begin
          period_count_next = period_bump;
        end else begin
          period_count_next = '0;
          cmd.roll_insert = 1'b1;
          cmd.publish = 1'b1;
        end
      end else begin
        case (phase)
          PH_CAPTURE: begin
            if (cap_index != '0 && period_bump < cfg.period) begin
              period_count_next = period_bump;
            end else begin
              period_count_next = '0;
              cmd.cap_write = 1'b1;
              if (cap_index == LAST_IDX) begin
                cmd.publish = 1'b1;
                cmd.tflag = timeout_flag;
                phase_next = PH_WAIT_LOW;
                arm_count_next = '0;
                cap_index_next = '0;
                timeout_flag_next = 1'b0;
              end else begin
                cap_index_next = cap_index + 1'b1;
              end
            end
          end
          PH_WAIT_HIGH: begin
            arm_count_next = arm_bump;
            if (code >= level) begin
              phase_next = PH_CAPTURE;
              timeout_flag_next = 1'b0;
              cap_index_next = '0;
              period_count_next = '0;
            end else if (arm_bump >= cfg.timeout) begin
              phase_next = PH_CAPTURE;
              timeout_flag_next = 1'b1;
              cap_index_next = '0;
              period_count_next = '0;
            end
          end
          default: begin
            // waiting for the low level; stray codes land here too
            arm_count_next = arm_bump;
            phase_next = (code <= level) ? PH_WAIT_HIGH : PH_WAIT_LOW;
            if (arm_bump >= cfg.timeout) begin
              phase_next = PH_CAPTURE;
              timeout_flag_next = 1'b1;
              cap_index_next = '0;
              period_count_next = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT_LOW;
      period_count <= '0;
      arm_count <= '0;
      cap_index <= '0;
      timeout_flag <= 1'b0;
    end else begin
      phase <= phase_next;
      period_count <= period_count_next;
      arm_count <= arm_count_next;
      cap_index <= cap_index_next;
      timeout_flag <= timeout_flag_next;
    end
  end

endmodule

### sim/scope_trigger_capture_tb.sv
// self-checking testbench of scope_trigger_capture: queued converter ticks and frame checks
module scope_trigger_capture_tb import stc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 12;
  localparam int DEPTH        = FRAME_DEPTH_DEF;
  localparam int SBITS        = SAMPLE_BITS_DEF;
  localparam int RANDOM_ITEMS = 180;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = DEPTH + 8;
  localparam int LIMIT_CYCLES = 1000000;

  localparam logic             MODE_TRIGGERED = 1'b1;
  localparam logic [SBITS-1:0] CODE_MAX       = '1;

  typedef struct packed {
    logic [SBITS-1:0] sample;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             tout;
  } frame_beat_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  stc_tick_if  #(.SAMPLE_BITS(SBITS)) tick_ch ();
  stc_frame_if #(.SAMPLE_BITS(SBITS)) frame_ch ();

  scope_trigger_capture #(
    .FRAME_DEPTH(DEPTH),
    .SAMPLE_BITS(SBITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .tick     (tick_ch),
    .frame    (frame_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // acquisition predictor state
  cfg_t               mcfg;
  logic [SBITS-1:0]   acq_store [DEPTH];
  logic [POS_W-1:0]   win_head;
  phase_t             acq_phase;
  logic [COUNT_W-1:0] period_cnt;
  logic [COUNT_W-1:0] arm_cnt;
  int                 cap_idx;
  logic               tflag;

  frame_beat_t      frame_beats_due [$];
  logic [SBITS-1:0] pending_codes [$];

  int   errors;
  int   queued;
  bit   tx_gaps_on;
  bit   rx_stalls_on;
  int   tx_gap;
  int   tx_draw;
  int   rx_wait;
  int   rx_draw;
  int   hold_seq;
  int   hold_seen;
  int   hold_left;
  frame_beat_t due;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic void rearm_acq();
    acq_phase  = PH_WAIT_LOW;
    period_cnt = '0;
    arm_cnt    = '0;
    cap_idx    = 0;
    tflag      = 1'b0;
  endfunction

  // whole stored frame, oldest entry at start
  function automatic void emit_frame(input logic [POS_W-1:0] start, input logic tf);
    frame_beat_t b;
    for (int k = 0; k < DEPTH; k++) begin
      b.sample = acq_store[start + POS_W'(k)];
      b.pos    = POS_W'(k);
      b.last   = (k == DEPTH - 1);
      b.tout   = tf;
      frame_beats_due.push_back(b);
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE: begin
        if (data[0] != mcfg.mode) begin
          mcfg.mode = data[0];
          rearm_acq();
        end
      end
      REG_PERIOD:  mcfg.period = data;
      REG_LEVEL:   mcfg.level = data[LEVEL_W-1:0];
      REG_TIMEOUT: mcfg.timeout = data;
      default: ;
    endcase
  endfunction

  function automatic void acquire_tick(input logic [SBITS-1:0] code);
    logic [COUNT_W-1:0] elapsed;
    logic               tf;
    if (mcfg.mode == MODE_ROLL) begin
      elapsed = sat_inc(period_cnt);
      if (elapsed < mcfg.period) begin
        period_cnt = elapsed;
      end else begin
        period_cnt = '0;
        acq_store[win_head] = code;
        win_head = win_head + 1'b1;
        emit_frame(win_head, 1'b0);
      end
    end else if (acq_phase == PH_CAPTURE) begin
      // first capture sample ignores the period
      elapsed = sat_inc(period_cnt);
      if (cap_idx != 0 && elapsed < mcfg.period) begin
        period_cnt = elapsed;
      end else begin
        period_cnt = '0;
        acq_store[cap_idx] = code;
        cap_idx++;
        if (cap_idx >= DEPTH) begin
          tf = tflag;
          win_head = '0;
          rearm_acq();
          emit_frame('0, tf);
        end
      end
    end else begin
      arm_cnt = sat_inc(arm_cnt);
      if (acq_phase == PH_WAIT_HIGH && code >= mcfg.level) begin
        // crossing wins over a timeout on the same tick
        acq_phase  = PH_CAPTURE;
        tflag      = 1'b0;
        cap_idx    = 0;
        period_cnt = '0;
      end else begin
        if (acq_phase != PH_WAIT_HIGH) begin
          if (code <= mcfg.level) acq_phase = PH_WAIT_HIGH;
          else acq_phase = PH_WAIT_LOW;
        end
        if (arm_cnt >= mcfg.timeout) begin
          acq_phase  = PH_CAPTURE;
          tflag      = 1'b1;
          cap_idx    = 0;
          period_cnt = '0;
        end
      end
    end
  endfunction

  // tick driver
  always @(posedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else if (tick_ch.valid && tick_ch.ready) begin
      acquire_tick(tick_ch.adc_code);
      tx_draw = tx_gaps_on ? $urandom_range(0, 3) : 0;
      if (tx_draw == 0 && pending_codes.size() > 0) begin
        tick_ch.adc_code <= pending_codes.pop_front();
      end else begin
        tick_ch.valid <= 1'b0;
        tx_gap <= tx_draw;
      end
    end else if (!tick_ch.valid) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
      end else if (pending_codes.size() > 0) begin
        tick_ch.valid <= 1'b1;
        tick_ch.adc_code <= pending_codes.pop_front();
      end
    end
  end

  // frame receiver ready, with per-beat stalls and the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.ready <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= LONG_HOLD;
      frame_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      frame_ch.ready <= (hold_left == 1);
    end else if (frame_ch.valid && frame_ch.ready) begin
      rx_draw = rx_stalls_on ? $urandom_range(0, 3) : 0;
      rx_wait <= rx_draw;
      frame_ch.ready <= (rx_draw == 0);
    end else if (!frame_ch.ready) begin
      if (rx_wait > 1) begin
        rx_wait <= rx_wait - 1;
      end else begin
        rx_wait <= 0;
        frame_ch.ready <= 1'b1;
      end
    end
  end

  // frame monitor
  always @(posedge clk) begin
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (frame_beats_due.size() == 0) begin
        $error("frame beat with nothing expected: frame_sample %0d, sample_position %0d",
               frame_ch.frame_sample, frame_ch.sample_position);
        errors++;
      end else begin
        due = frame_beats_due.pop_front();
        if (frame_ch.frame_sample !== due.sample) begin
          $error("frame_sample: expected %0d, actual %0d", due.sample, frame_ch.frame_sample);
          errors++;
        end
        if (frame_ch.sample_position !== due.pos) begin
          $error("sample_position: expected %0d, actual %0d", due.pos,
                 frame_ch.sample_position);
          errors++;
        end
        if (frame_ch.frame_last !== due.last) begin
          $error("frame_last: expected %0d, actual %0d", due.last, frame_ch.frame_last);
          errors++;
        end
        if (frame_ch.timed_out !== due.tout) begin
          $error("timed_out: expected %0d, actual %0d", due.tout, frame_ch.timed_out);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    apply_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sampled at the falling edge so the driver and monitor have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_codes.size() != 0 || tick_ch.valid || frame_beats_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mode goes last so a realignment never overlaps another write
  task automatic set_config(input logic [COUNT_W-1:0] prd, input logic [LEVEL_W-1:0] lvl,
                            input logic [COUNT_W-1:0] tmo, input logic m);
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    write_reg(REG_PERIOD, prd);
    data = CFG_DATA_W'($urandom);
    data[LEVEL_W-1:0] = lvl;
    write_reg(REG_LEVEL, data);
    write_reg(REG_TIMEOUT, tmo);
    data = CFG_DATA_W'($urandom);
    data[0] = m;
    write_reg(REG_MODE, data);
  endtask

  task automatic queue_code(input logic [SBITS-1:0] c);
    pending_codes.push_back(c);
    queued++;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: queue_code('0);
        1: queue_code(CODE_MAX);
        default: queue_code(SBITS'($urandom_range(0, CODE_MAX)));
      endcase
    end
  endtask

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int                 pick;
    int                 rand_base;
    logic [COUNT_W-1:0] prd;
    logic [COUNT_W-1:0] tmo;
    logic [LEVEL_W-1:0] lvl;
    logic [CFG_DATA_W-1:0] data;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.adc_code = '0;
    frame_ch.ready = 1'b0;
    errors = 0;
    queued = 0;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    hold_seq = 0;
    tx_gap = 0;
    rx_wait = 0;

    mcfg.mode = MODE_RESET;
    mcfg.period = PERIOD_RESET;
    mcfg.level = LEVEL_RESET;
    mcfg.timeout = TIMEOUT_RESET;
    for (int i = 0; i < DEPTH; i++) acq_store[i] = '0;
    win_head = '0;
    rearm_acq();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // roll mode, every tick publishes; first frame shows the cleared store
    set_config('0, LEVEL_RESET, TIMEOUT_RESET, MODE_ROLL);
    queue_code('0);
    queue_code(CODE_MAX);
    queue_code(12'hAAA);
    queue_code(12'h555);
    queue_code(12'h001);
    queue_code(12'hFFE);

    // rewriting the same mode must keep the elapsed count
    set_config(16'd3, LEVEL_RESET, TIMEOUT_RESET, MODE_ROLL);
    queue_code(12'h800);
    queue_code(12'h7FF);
    wait_idle();
    data = CFG_DATA_W'($urandom);
    data[0] = MODE_ROLL;
    write_reg(REG_MODE, data);
    queue_code(CODE_MAX);

    // crossing on the same tick as the timeout counts as a trigger
    set_config('0, 12'd2048, 16'd3, MODE_TRIGGERED);
    queue_code(12'd3000);
    queue_code(12'd2048);
    queue_code(12'd2048);
    queue_random(DEPTH);

    // zero timeout forces capture on the first armed tick
    set_config(16'd1, CODE_MAX, '0, MODE_TRIGGERED);
    queue_code(12'd1);
    queue_random(DEPTH);

    // longest period: no sample is due
    set_config(COUNT_MAX, '0, COUNT_MAX, MODE_ROLL);
    queue_random(8);

    // receiver holds off while ticks keep coming; the block has to back up
    set_config('0, LEVEL_RESET, TIMEOUT_RESET, MODE_ROLL);
    tx_gaps_on = 1'b0;
    hold_seq++;
    queue_random(12);

    rand_base = queued;
    while (queued - rand_base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case ($urandom_range(0, 5))
        0: lvl = '0;
        1: lvl = CODE_MAX;
        default: lvl = LEVEL_W'($urandom_range(0, CODE_MAX));
      endcase
      case ($urandom_range(0, 3))
        0: tmo = '0;
        1: tmo = COUNT_W'($urandom_range(1, 40));
        2: tmo = COUNT_MAX;
        default: tmo = COUNT_W'($urandom_range(0, COUNT_MAX));
      endcase
      if (pick < 5) begin
        prd = (pick == 0) ? COUNT_W'($urandom_range(4, COUNT_MAX))
                          : COUNT_W'($urandom_range(0, 3));
        set_config(prd, lvl, tmo, MODE_ROLL);
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
        queue_random((prd > 3) ? 8 : $urandom_range(10, 30));
      end else begin
        prd = COUNT_W'($urandom_range(0, 2));
        set_config(prd, lvl, tmo, MODE_TRIGGERED);
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
        if (pick == 9) begin
          // stray codes: may time out or cross at random
          queue_random($urandom_range(5, 40));
        end else begin
          queue_random($urandom_range(0, 3));
          queue_code(SBITS'($urandom_range(0, lvl)));
          if (lvl != 0)
            repeat ($urandom_range(0, 2)) queue_code(SBITS'($urandom_range(0, lvl - 1)));
          queue_code(SBITS'($urandom_range(lvl, CODE_MAX)));
          queue_random(1 + (DEPTH - 1) * ((prd == 0) ? 1 : prd));
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
